// ===== design/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants for the pressure sensor compensation block:
// calibration word record, register indexes and datapath widths.
// ----------------------------------------------------------------------------
package psc_pkg;

    // configuration port
    localparam int CAL_W     = 16;
    localparam int CFG_IDX_W = 3;

    // stream payloads
    localparam int RAW_W   = 24;
    localparam int TOUT_W  = 19;
    localparam int POUT_W  = 28;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // pipeline depth, output register included
    localparam int NUM_ST = 12;

    // internal widths
    localparam int TEMP_W = 20;

    localparam logic signed [TEMP_W-1:0] TEMP_REF  = 20'sd2000;
    localparam logic signed [TEMP_W-1:0] VLOW_REF  = -20'sd1500;
    localparam logic signed [TEMP_W-1:0] VLOW_OFS  = 20'sd1500;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_C1 = 3'd0,
        REG_C2 = 3'd1,
        REG_C3 = 3'd2,
        REG_C4 = 3'd3,
        REG_C5 = 3'd4,
        REG_C6 = 3'd5
    } t_cfg_idx;

    // calibration words
    typedef struct packed {
        logic [CAL_W-1:0] c1;
        logic [CAL_W-1:0] c2;
        logic [CAL_W-1:0] c3;
        logic [CAL_W-1:0] c4;
        logic [CAL_W-1:0] c5;
        logic [CAL_W-1:0] c6;
    } t_cal;

endpackage

// ===== design/psc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// psc_cfg_regs
// Holds the six calibration words; decodes the register index on each write
// and drops writes to indexes beyond the list.
// ----------------------------------------------------------------------------
module psc_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [psc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [psc_pkg::CAL_W-1:0]      i_cfg_data,
    output psc_pkg::t_cal                  o_cal
);
    import psc_pkg::*;

    t_cal r_cal;

    // write the addressed word, ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_C1: begin
                    r_cal.c1 <= i_cfg_data;
                end
                REG_C2: begin
                    r_cal.c2 <= i_cfg_data;
                end
                REG_C3: begin
                    r_cal.c3 <= i_cfg_data;
                end
                REG_C4: begin
                    r_cal.c4 <= i_cfg_data;
                end
                REG_C5: begin
                    r_cal.c5 <= i_cfg_data;
                end
                REG_C6: begin
                    r_cal.c6 <= i_cfg_data;
                end
                default: begin
                    r_cal <= r_cal;
                end
            endcase
        end
    end

    assign o_cal = r_cal;

endmodule

// ===== design/pressure_sensor_compensation.sv =====
// ----------------------------------------------------------------------------
// pressure_sensor_compensation
// Second-order compensation of raw pressure and temperature conversions
// using six calibration words; pipelined, one beat per cycle while m_axis is not stalled.
// ----------------------------------------------------------------------------
//  channel   | direction | contents (lowest bits first)
//  ----------+-----------+---------------------------------------------------
//  s_axis    | in        | raw_pressure[23:0], raw_temperature[47:24]
//  m_axis    | out       | temperature_centideg[18:0], pressure_value[46:19]
//  i_cfg_*   | in        | write enable, register index 0..5, 16-bit word
//
//  A new beat is taken every cycle unless stage 1 is full and held by
//  back-pressure from m_axis. The depth is set by the dT products, the
//  squared temperature deviations and the 24 x 42 bit pressure product,
//  which is split into two partial products over two stages.
//  Reset clears the valid bits and the calibration words to zero.
//  Each stage holds while the one after it is full and stalled, so empty
//  stages keep filling while the output beat waits.
// ----------------------------------------------------------------------------
module pressure_sensor_compensation (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // raw_pressure [23:0], raw_temperature [47:24]
    input  logic [psc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // temperature_centideg [18:0], pressure_value [46:19], zero [47]
    output logic [psc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic                           i_cfg_we,
    input  logic [psc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [psc_pkg::CAL_W-1:0]      i_cfg_data
);
    import psc_pkg::*;

    t_cal w_cal;

    logic [NUM_ST:1] r_vld;
    logic [NUM_ST:1] w_en;

    psc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cal       (w_cal)
    );

    // stage enables: a stage loads when empty or when the next one loads
    always_comb begin
        w_en[NUM_ST] = !r_vld[NUM_ST] || m_axis_tready;
        for (int k = NUM_ST - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    // hold off input beats while in reset
    assign s_axis_tready = w_en[1] && i_rst_n;

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= NUM_ST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: dT = D2 - C5 * 256
    // ------------------------------------------------------------------
    logic        [RAW_W-1:0] r_s1_d1;
    logic signed [24:0]      r_s1_dt;
    logic signed [24:0]      n_s1_dt;

    always_comb begin
        n_s1_dt = $signed({1'b0, s_axis_tdata[47:24]}) - $signed({1'b0, w_cal.c5, 8'd0});
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s1_d1 <= s_axis_tdata[23:0];
            r_s1_dt <= n_s1_dt;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: dT products and dT squared
    // ------------------------------------------------------------------
    logic        [RAW_W-1:0] r_s2_d1;
    logic signed [41:0]      r_s2_p6, r_s2_p4, r_s2_p3;
    logic signed [41:0]      n_s2_p6, n_s2_p4, n_s2_p3;
    logic        [47:0]      r_s2_sq, n_s2_sq;
    logic signed [24:0]      w_dt_neg;
    logic        [23:0]      w_dt_mag;

    always_comb begin
        n_s2_p6  = r_s1_dt * $signed({1'b0, w_cal.c6});
        n_s2_p4  = r_s1_dt * $signed({1'b0, w_cal.c4});
        n_s2_p3  = r_s1_dt * $signed({1'b0, w_cal.c3});
        w_dt_neg = -r_s1_dt;
        w_dt_mag = r_s1_dt[24] ? w_dt_neg[23:0] : r_s1_dt[23:0];
        n_s2_sq  = w_dt_mag * w_dt_mag;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s2_d1 <= r_s1_d1;
            r_s2_p6 <= n_s2_p6;
            r_s2_p4 <= n_s2_p4;
            r_s2_p3 <= n_s2_p3;
            r_s2_sq <= n_s2_sq;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: TEMP, OFF, SENS and both Ti candidates
    // ------------------------------------------------------------------
    logic        [RAW_W-1:0]  r_s3_d1;
    logic signed [TEMP_W-1:0] r_s3_temp, n_s3_temp;
    logic signed [35:0]       r_s3_off, n_s3_off;
    logic signed [34:0]       r_s3_sens, n_s3_sens;
    logic        [16:0]       r_s3_ti_low;
    logic        [11:0]       r_s3_ti_high;
    logic signed [41:0]       w_p6_adj, w_p4_adj, w_p3_adj;
    logic signed [41:0]       w_q6, w_q4, w_q3;
    logic        [49:0]       w_sq3;

    // signed divides by powers of two round toward zero
    always_comb begin
        w_p6_adj  = r_s2_p6 + (r_s2_p6[41] ? 42'sd8388607 : 42'sd0);
        w_p4_adj  = r_s2_p4 + (r_s2_p4[41] ? 42'sd127 : 42'sd0);
        w_p3_adj  = r_s2_p3 + (r_s2_p3[41] ? 42'sd255 : 42'sd0);
        w_q6      = w_p6_adj >>> 23;
        w_q4      = w_p4_adj >>> 7;
        w_q3      = w_p3_adj >>> 8;
        n_s3_temp = $signed(w_q6[TEMP_W-1:0]) + TEMP_REF;
        n_s3_off  = $signed({4'd0, w_cal.c2, 16'd0}) + $signed(w_q4[35:0]);
        n_s3_sens = $signed({4'd0, w_cal.c1, 15'd0}) + $signed(w_q3[34:0]);
        w_sq3     = {2'b00, r_s2_sq} + {1'b0, r_s2_sq, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s3_d1      <= r_s2_d1;
            r_s3_temp    <= n_s3_temp;
            r_s3_off     <= n_s3_off;
            r_s3_sens    <= n_s3_sens;
            r_s3_ti_low  <= w_sq3[49:33];
            r_s3_ti_high <= r_s2_sq[47:36];
        end
    end

    // ------------------------------------------------------------------
    // stage 4: range flags, deviations, corrected temperature
    // ------------------------------------------------------------------
    logic        [RAW_W-1:0]  r_s4_d1;
    logic signed [35:0]       r_s4_off;
    logic signed [34:0]       r_s4_sens;
    logic                     r_s4_low, r_s4_vlow;
    logic        [17:0]       r_s4_dev_mag, r_s4_vl_mag;
    logic signed [TEMP_W-1:0] r_s4_temp2, n_s4_temp2;
    logic                     w_low, w_vlow;
    logic signed [TEMP_W-1:0] w_dev, w_vl, w_dev_neg, w_vl_neg;
    logic        [17:0]       n_s4_dev_mag, n_s4_vl_mag;

    always_comb begin
        w_low        = r_s3_temp < TEMP_REF;
        w_vlow       = r_s3_temp < VLOW_REF;
        w_dev        = r_s3_temp - TEMP_REF;
        w_vl         = r_s3_temp + VLOW_OFS;
        w_dev_neg    = -w_dev;
        w_vl_neg     = -w_vl;
        n_s4_dev_mag = w_dev[TEMP_W-1] ? w_dev_neg[17:0] : w_dev[17:0];
        n_s4_vl_mag  = w_vl[TEMP_W-1] ? w_vl_neg[17:0] : w_vl[17:0];
        n_s4_temp2   = r_s3_temp - (w_low ? $signed({3'd0, r_s3_ti_low})
                                          : $signed({8'd0, r_s3_ti_high}));
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_s4_d1      <= r_s3_d1;
            r_s4_off     <= r_s3_off;
            r_s4_sens    <= r_s3_sens;
            r_s4_low     <= w_low;
            r_s4_vlow    <= w_vlow;
            r_s4_dev_mag <= n_s4_dev_mag;
            r_s4_vl_mag  <= n_s4_vl_mag;
            r_s4_temp2   <= n_s4_temp2;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: square the deviations
    // ------------------------------------------------------------------
    logic        [RAW_W-1:0]  r_s5_d1;
    logic signed [35:0]       r_s5_off;
    logic signed [34:0]       r_s5_sens;
    logic                     r_s5_low, r_s5_vlow;
    logic        [35:0]       r_s5_dev2, r_s5_vl2;
    logic signed [TEMP_W-1:0] r_s5_temp2;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_s5_d1    <= r_s4_d1;
            r_s5_off   <= r_s4_off;
            r_s5_sens  <= r_s4_sens;
            r_s5_low   <= r_s4_low;
            r_s5_vlow  <= r_s4_vlow;
            r_s5_dev2  <= r_s4_dev_mag * r_s4_dev_mag;
            r_s5_vl2   <= r_s4_vl_mag * r_s4_vl_mag;
            r_s5_temp2 <= r_s4_temp2;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: second-order offset and sensitivity terms
    // ------------------------------------------------------------------
    logic        [RAW_W-1:0]  r_s6_d1;
    logic signed [35:0]       r_s6_off;
    logic signed [34:0]       r_s6_sens;
    logic        [39:0]       r_s6_offi, r_s6_sensi, n_s6_offi, n_s6_sensi;
    logic signed [TEMP_W-1:0] r_s6_temp2;
    logic        [39:0]       w_dev2, w_vl2, w_dev2x3, w_dev2x5, w_vl2x7, w_vl2x4;

    always_comb begin
        w_dev2   = {4'd0, r_s5_dev2};
        w_vl2    = {4'd0, r_s5_vl2};
        w_dev2x3 = w_dev2 + (w_dev2 << 1);
        w_dev2x5 = w_dev2 + (w_dev2 << 2);
        w_vl2x7  = (w_vl2 << 3) - w_vl2;
        w_vl2x4  = w_vl2 << 2;
        priority if (!r_s5_low) begin
            n_s6_offi  = w_dev2 >> 4;
            n_s6_sensi = '0;
        end else if (r_s5_vlow) begin
            n_s6_offi  = (w_dev2x3 >> 1) + w_vl2x7;
            n_s6_sensi = (w_dev2x5 >> 3) + w_vl2x4;
        end else begin
            n_s6_offi  = w_dev2x3 >> 1;
            n_s6_sensi = w_dev2x5 >> 3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_s6_d1    <= r_s5_d1;
            r_s6_off   <= r_s5_off;
            r_s6_sens  <= r_s5_sens;
            r_s6_offi  <= n_s6_offi;
            r_s6_sensi <= n_s6_sensi;
            r_s6_temp2 <= r_s5_temp2;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: OFF2 and SENS2
    // ------------------------------------------------------------------
    logic        [RAW_W-1:0]  r_s7_d1;
    logic signed [41:0]       r_s7_off2, r_s7_sens2, n_s7_off2, n_s7_sens2;
    logic signed [TEMP_W-1:0] r_s7_temp2;

    always_comb begin
        n_s7_off2  = $signed({{6{r_s6_off[35]}}, r_s6_off}) - $signed({2'b00, r_s6_offi});
        n_s7_sens2 = $signed({{7{r_s6_sens[34]}}, r_s6_sens}) - $signed({2'b00, r_s6_sensi});
    end

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_s7_d1    <= r_s6_d1;
            r_s7_off2  <= n_s7_off2;
            r_s7_sens2 <= n_s7_sens2;
            r_s7_temp2 <= r_s6_temp2;
        end
    end

    // ------------------------------------------------------------------
    // stage 8: D1 * SENS2 as two partial products (low half unsigned)
    // ------------------------------------------------------------------
    logic        [44:0]       r_s8_lo, n_s8_lo;
    logic signed [45:0]       r_s8_hi, n_s8_hi;
    logic signed [41:0]       r_s8_off2;
    logic signed [TEMP_W-1:0] r_s8_temp2;

    always_comb begin
        n_s8_lo = r_s7_d1 * r_s7_sens2[20:0];
        n_s8_hi = $signed({1'b0, r_s7_d1}) * $signed(r_s7_sens2[41:21]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r_s8_lo    <= n_s8_lo;
            r_s8_hi    <= n_s8_hi;
            r_s8_off2  <= r_s7_off2;
            r_s8_temp2 <= r_s7_temp2;
        end
    end

    // ------------------------------------------------------------------
    // stage 9: combine partial products
    // ------------------------------------------------------------------
    logic signed [66:0]       r_s9_prod, n_s9_prod;
    logic signed [41:0]       r_s9_off2;
    logic signed [TEMP_W-1:0] r_s9_temp2;

    always_comb begin
        n_s9_prod = $signed({r_s8_hi, 21'd0}) + $signed({22'd0, r_s8_lo});
    end

    always_ff @(posedge i_clk) begin
        if (w_en[9]) begin
            r_s9_prod  <= n_s9_prod;
            r_s9_off2  <= r_s8_off2;
            r_s9_temp2 <= r_s8_temp2;
        end
    end

    // ------------------------------------------------------------------
    // stage 10: product / 2^21 toward zero
    // ------------------------------------------------------------------
    logic signed [45:0]       r_s10_q1;
    logic signed [41:0]       r_s10_off2;
    logic signed [TEMP_W-1:0] r_s10_temp2;
    logic signed [66:0]       w_prod_adj, w_q1;

    always_comb begin
        w_prod_adj = r_s9_prod + (r_s9_prod[66] ? 67'sd2097151 : 67'sd0);
        w_q1       = w_prod_adj >>> 21;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[10]) begin
            r_s10_q1    <= w_q1[45:0];
            r_s10_off2  <= r_s9_off2;
            r_s10_temp2 <= r_s9_temp2;
        end
    end

    // ------------------------------------------------------------------
    // stage 11: subtract OFF2
    // ------------------------------------------------------------------
    logic signed [46:0]       r_s11_x, n_s11_x;
    logic signed [TEMP_W-1:0] r_s11_temp2;

    always_comb begin
        n_s11_x = $signed({r_s10_q1[45], r_s10_q1})
                - $signed({{5{r_s10_off2[41]}}, r_s10_off2});
    end

    always_ff @(posedge i_clk) begin
        if (w_en[11]) begin
            r_s11_x     <= n_s11_x;
            r_s11_temp2 <= r_s10_temp2;
        end
    end

    // ------------------------------------------------------------------
    // stage 12: / 2^13 toward zero, saturate, output register
    // ------------------------------------------------------------------
    logic signed [POUT_W-1:0] r_s12_pres, n_s12_pres;
    logic signed [TOUT_W-1:0] r_s12_temp, n_s12_temp;
    logic signed [46:0]       w_x_adj, w_p;

    always_comb begin
        w_x_adj = r_s11_x + (r_s11_x[46] ? 47'sd8191 : 47'sd0);
        w_p     = w_x_adj >>> 13;
        priority if (w_p > 47'sd134217727) begin
            n_s12_pres = {1'b0, {(POUT_W-1){1'b1}}};
        end else if (w_p < -47'sd134217728) begin
            n_s12_pres = {1'b1, {(POUT_W-1){1'b0}}};
        end else begin
            n_s12_pres = w_p[POUT_W-1:0];
        end
        priority if (r_s11_temp2 > 20'sd262143) begin
            n_s12_temp = {1'b0, {(TOUT_W-1){1'b1}}};
        end else if (r_s11_temp2 < -20'sd262144) begin
            n_s12_temp = {1'b1, {(TOUT_W-1){1'b0}}};
        end else begin
            n_s12_temp = r_s11_temp2[TOUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[12]) begin
            r_s12_pres <= n_s12_pres;
            r_s12_temp <= n_s12_temp;
        end
    end

    assign m_axis_tvalid = r_vld[NUM_ST];
    assign m_axis_tdata  = {1'b0, r_s12_pres, r_s12_temp};

endmodule
